/* sv/tccw_pkg.sv */
`default_nettype none
package tccw_pkg;

	localparam int CMD_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int CELL_W  = 16;
	localparam int ATTR_W  = 8;

	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

	typedef enum logic [9:0] {
		ST_INIT    = 10'b00_0000_0001,
		ST_IDLE    = 10'b00_0000_0010,
		ST_PUT     = 10'b00_0000_0100,
		ST_RD      = 10'b00_0000_1000,
		ST_RD_WAIT = 10'b00_0001_0000,
		ST_SC_RD   = 10'b00_0010_0000,
		ST_SC_WR   = 10'b00_0100_0000,
		ST_ZERO    = 10'b00_1000_0000,
		ST_DONE    = 10'b01_0000_0000,
		ST_SPARE   = 10'b10_0000_0000
	} state_t;

endpackage
`default_nettype wire

/* sv/tccw_ram.sv */
`default_nettype none
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* sv/text_console_cursor_writer.sv */
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_ready | command, char_code, read_row, read_col
// out     | output    | out_valid/out_ready | cursor_col_out, cursor_row_out,
//         |           |                     | cell_value, scrolled
// cfg     | input     | wr_en (no wait)     | wr_data (text attribute)
//
// Accept to result: put, tab and newline pass ST_PUT and ST_DONE; read passes ST_RD,
// ST_RD_WAIT and ST_DONE; an unused command goes straight to ST_DONE. A scroll adds
// ST_SC_RD and ST_SC_WR per cell moved (one read and one write through the single
// cell-store port pair), then ST_ZERO blanks the bottom row. Clear: ST_ZERO zeroes
// all (LAST_ROW+1)*COLUMNS cells, one cell per cycle; after reset a like pass runs with in_ready low.
// One item at a time; a result held at the output stalls only the end of the next item.
`default_nettype none
module text_console_cursor_writer #(
	parameter int COLUMNS  = 80,
	parameter int LAST_ROW = 24,
	parameter int TAB_STEP = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [tccw_pkg::CMD_W-1:0]    command,
	input  wire logic [tccw_pkg::CHAR_W-1:0]   char_code,
	input  wire logic [tccw_pkg::ROW_W-1:0]    read_row,
	input  wire logic [tccw_pkg::COL_W-1:0]    read_col,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [tccw_pkg::COL_W-1:0]    cursor_col_out,
	output logic      [tccw_pkg::ROW_W-1:0]    cursor_row_out,
	output logic      [tccw_pkg::CELL_W-1:0]   cell_value,
	output logic                               scrolled,
	input  wire logic                          wr_en,
	input  wire logic [tccw_pkg::ATTR_W-1:0]   wr_data
);
	import tccw_pkg::*;

	localparam int CELLS = (LAST_ROW + 1) * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
	localparam logic [AW-1:0] FIRST_SRC   = AW'(COLUMNS);
	localparam logic [AW-1:0] BOTTOM_ROW  = AW'(LAST_ROW * COLUMNS);

	state_t state_q;
	logic [AW-1:0]     addr_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [ATTR_W-1:0] attr_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [CHAR_W-1:0] char_q;
	logic [ROW_W-1:0]  rrow_q;
	logic [COL_W-1:0]  rcol_q;
	logic [CELL_W-1:0] cell_q;
	logic              scroll_q;
	logic              out_valid_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [CELL_W-1:0] out_cell_q;
	logic              out_scroll_q;

	logic              accept;
	logic              out_load;
	logic              ordinary;
	logic              read_ok;
	logic [ROW_W-1:0]  row_sel;
	logic [COL_W-1:0]  col_sel;
	logic [AW-1:0]     lin_addr;
	logic [7:0]        x_step;
	logic [7:0]        x_wrap;
	logic [5:0]        y_step;
	logic [5:0]        y_wrap;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign ordinary = (char_q != CHAR_NEWLINE) && (char_q != CHAR_TAB);
	assign read_ok  = (rrow_q <= ROW_W'(LAST_ROW)) && (rcol_q < COL_W'(COLUMNS));

	// one row-times-columns unit serves the put address and the read address
	assign row_sel  = (state_q == ST_PUT) ? cur_row_q : rrow_q;
	assign col_sel  = (state_q == ST_PUT) ? cur_col_q : rcol_q;
	assign lin_addr = AW'(32'(row_sel) * 32'(COLUMNS) + 32'(col_sel));

	always_comb begin
		x_step = {1'b0, cur_col_q} + 8'd1;
		y_step = {1'b0, cur_row_q};
		if (char_q == CHAR_NEWLINE) begin
			x_step = 8'd0;
			y_step = {1'b0, cur_row_q} + 6'd1;
		end else if (char_q == CHAR_TAB) begin
			x_step = {1'b0, cur_col_q} + 8'(TAB_STEP);
		end
		x_wrap = x_step;
		y_wrap = y_step;
		if (x_step >= 8'(COLUMNS)) begin
			x_wrap = x_step - 8'(COLUMNS);
			y_wrap = y_step + 6'd1;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_raddr = addr_q;
		case (state_q)
			ST_PUT: begin
				ram_we    = ordinary;
				ram_waddr = lin_addr;
				ram_wdata = {attr_q, char_q};
			end
			ST_RD: begin
				ram_raddr = lin_addr;
			end
			ST_SC_WR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(32'(addr_q) - 32'(COLUMNS));
				ram_wdata = ram_rdata;
			end
			ST_INIT, ST_ZERO: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	tccw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (wr_en) begin
			attr_q <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command;
			char_q <= char_code;
			rrow_q <= read_row;
			rcol_q <= read_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			addr_q      <= '0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			cell_q      <= '0;
			scroll_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_INIT: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == LAST_CELL) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cell_q   <= '0;
						scroll_q <= 1'b0;
						case (command)
							CMD_PUT:   state_q <= ST_PUT;
							CMD_READ:  state_q <= ST_RD;
							CMD_CLEAR: begin
								cur_col_q <= '0;
								cur_row_q <= '0;
								addr_q    <= '0;
								state_q   <= ST_ZERO;
							end
							default:   state_q <= ST_DONE;
						endcase
					end
				end
				ST_PUT: begin
					cur_col_q <= x_wrap[COL_W-1:0];
					if (y_wrap > 6'(LAST_ROW)) begin
						cur_row_q <= ROW_W'(LAST_ROW);
						scroll_q  <= 1'b1;
						addr_q    <= FIRST_SRC;
						state_q   <= ST_SC_RD;
					end else begin
						cur_row_q <= y_wrap[ROW_W-1:0];
						state_q   <= ST_DONE;
					end
				end
				ST_RD: begin
					state_q <= ST_RD_WAIT;
				end
				ST_RD_WAIT: begin
					cell_q  <= read_ok ? ram_rdata : '0;
					state_q <= ST_DONE;
				end
				ST_SC_RD: begin
					state_q <= ST_SC_WR;
				end
				ST_SC_WR: begin
					// move one cell up a row, then blank the bottom row
					if (addr_q == LAST_CELL) begin
						addr_q  <= BOTTOM_ROW;
						state_q <= ST_ZERO;
					end else begin
						addr_q  <= addr_q + AW'(1);
						state_q <= ST_SC_RD;
					end
				end
				ST_ZERO: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == LAST_CELL) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold the result until the output register frees up
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_col_q    <= cur_col_q;
			out_row_q    <= cur_row_q;
			out_cell_q   <= cell_q;
			out_scroll_q <= scroll_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign cursor_col_out = out_col_q;
	assign cursor_row_out = out_row_q;
	assign cell_value     = out_cell_q;
	assign scrolled       = out_scroll_q;

`ifndef SYNTHESIS
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_col_q < COL_W'(COLUMNS)) && (cur_row_q <= ROW_W'(LAST_ROW)))
		else $error("cursor left the screen");

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scrolled |-> cursor_row_out == ROW_W'(LAST_ROW))
		else $error("scroll reported with cursor off the last row");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in work");

	a_scroll_only_put: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SC_RD |-> cmd_q == CMD_PUT && scroll_q)
		else $error("scroll walk without a put");
`endif

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
module tb;
	import tccw_pkg::*;

	localparam int COLUMNS      = 80;
	localparam int LAST_ROW     = 24;
	localparam int TAB_STEP     = 4;
	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int SCROLL_QUOTA = 70;
	localparam int PHASES       = 6;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [CHAR_W-1:0] ch;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} console_cmd_t;

	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [CELL_W-1:0] cell_val;
		logic              scrolled;
	} console_report_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             scroll;
	} cursor_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CMD_W-1:0] command = '0;
	logic [CHAR_W-1:0] char_code = '0;
	logic [ROW_W-1:0] read_row = '0;
	logic [COL_W-1:0] read_col = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [COL_W-1:0] cursor_col_out;
	logic [ROW_W-1:0] cursor_row_out;
	logic [CELL_W-1:0] cell_value;
	logic scrolled;
	logic wr_en = 1'b0;
	logic [ATTR_W-1:0] wr_data = '0;

	console_cmd_t    cmd_backlog[$];
	console_report_t predicted_reports[$];

	logic [CELL_W-1:0] screen_image [LAST_ROW+1][COLUMNS];
	cursor_t           model_cursor;
	logic [ATTR_W-1:0] model_attr;
	cursor_t           plan_cursor;
	int                scrolls_left;
	int                items_queued = 0;
	int                fail_count = 0;
	int                cycle_count = 0;
	logic              in_taken = 1'b0;
	logic              idle_on = 1'b1;

	text_console_cursor_writer #(
		.COLUMNS (COLUMNS),
		.LAST_ROW(LAST_ROW),
		.TAB_STEP(TAB_STEP)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.char_code     (char_code),
		.read_row      (read_row),
		.read_col      (read_col),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cursor_col_out(cursor_col_out),
		.cursor_row_out(cursor_row_out),
		.cell_value    (cell_value),
		.scrolled      (scrolled),
		.wr_en         (wr_en),
		.wr_data       (wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic cursor_t advance_cursor(cursor_t cur, logic [CHAR_W-1:0] ch);
		int x;
		int y;
		cursor_t nxt;
		x = cur.col;
		y = cur.row;
		if (ch == CHAR_NEWLINE) begin
			x = 0;
			y++;
		end else if (ch == CHAR_TAB) begin
			x += TAB_STEP;
		end else begin
			x++;
		end
		if (x >= COLUMNS) begin
			y++;
			x = x % COLUMNS;
		end
		nxt.scroll = (y > LAST_ROW);
		if (y > LAST_ROW)
			y = LAST_ROW;
		nxt.col = x[COL_W-1:0];
		nxt.row = y[ROW_W-1:0];
		return nxt;
	endfunction

	function automatic void blank_screen();
		for (int r = 0; r <= LAST_ROW; r++)
			for (int k = 0; k < COLUMNS; k++)
				screen_image[r][k] = '0;
	endfunction

	task automatic apply_console_cmd(input console_cmd_t c, output console_report_t rep);
		cursor_t nxt;
		rep = '0;
		case (c.cmd)
			CMD_PUT: begin
				if (c.ch != CHAR_NEWLINE && c.ch != CHAR_TAB)
					screen_image[model_cursor.row][model_cursor.col] = {model_attr, c.ch};
				nxt = advance_cursor(model_cursor, c.ch);
				if (nxt.scroll) begin
					for (int r = 0; r < LAST_ROW; r++)
						for (int k = 0; k < COLUMNS; k++)
							screen_image[r][k] = screen_image[r+1][k];
					for (int k = 0; k < COLUMNS; k++)
						screen_image[LAST_ROW][k] = '0;
				end
				rep.scrolled = nxt.scroll;
				model_cursor = nxt;
			end
			CMD_CLEAR: begin
				blank_screen();
				model_cursor = '0;
			end
			CMD_READ: begin
				if (c.row <= LAST_ROW && c.col < COLUMNS)
					rep.cell_val = screen_image[c.row][c.col];
			end
			default: ;
		endcase
		rep.col = model_cursor.col;
		rep.row = model_cursor.row;
	endtask

	// Track the cursor at queue time so scrolls stay within budget; once the
	// budget is spent, a put that would scroll turns into a clear.
	task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
			input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
		console_cmd_t c;
		cursor_t nxt;
		c = '{cmd, ch, row, col};
		if (cmd == CMD_PUT) begin
			nxt = advance_cursor(plan_cursor, ch);
			if (nxt.scroll && scrolls_left == 0) begin
				c.cmd = CMD_CLEAR;
				nxt = '0;
			end else if (nxt.scroll) begin
				scrolls_left--;
			end
			plan_cursor = nxt;
			plan_cursor.scroll = 1'b0;
		end else if (cmd == CMD_CLEAR) begin
			plan_cursor = '0;
		end
		cmd_backlog.push_back(c);
		items_queued++;
	endtask

	task automatic queue_text_run(input int n, input int ctrl_pct);
		int p;
		logic [CHAR_W-1:0] ch;
		for (int k = 0; k < n; k++) begin
			p = $urandom_range(99);
			if (p < ctrl_pct)
				ch = (p % 2 == 0) ? CHAR_NEWLINE : CHAR_TAB;
			else
				ch = CHAR_W'($urandom_range(255));
			queue_cmd(CMD_PUT, ch, ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
		end
	endtask

	task automatic queue_reads(input int n);
		int r;
		int c;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(9) < 6) begin
				// aim near the rows just written
				r = int'(plan_cursor.row) - int'($urandom_range(2));
				if (r < 0)
					r = 0;
				c = $urandom_range(COLUMNS - 1);
			end else begin
				r = $urandom_range(31);
				c = $urandom_range(127);
			end
			queue_cmd(CMD_READ, CHAR_W'($urandom_range(255)), ROW_W'(r), COL_W'(c));
		end
	endtask

	task automatic queue_random_phase(input int n);
		int goal;
		int pick;
		goal = items_queued + n;
		while (items_queued < goal) begin
			pick = $urandom_range(99);
			if (pick < 50)
				queue_text_run($urandom_range(1, 40), 16);
			else if (pick < 60)
				queue_text_run($urandom_range(60, 120), 4);
			else if (pick < 88)
				queue_reads($urandom_range(1, 6));
			else if (pick < 95)
				queue_cmd(CMD_UNUSED, CHAR_W'($urandom_range(255)),
					ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
			else
				queue_cmd(CMD_CLEAR, CHAR_W'($urandom_range(255)),
					ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
		end
	endtask

	task automatic wait_until_drained();
		while (cmd_backlog.size() != 0 || in_valid || predicted_reports.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	// Driver: hold the item until taken, then advance or idle.
	always @(negedge clk) begin : driver
		console_cmd_t c;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (cmd_backlog.size() != 0 && !(idle_on && $urandom_range(99) < 23)) begin
					c = cmd_backlog.pop_front();
					command <= c.cmd;
					char_code <= c.ch;
					read_row <= c.row;
					read_col <= c.col;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= !(idle_on && $urandom_range(99) < 23);
		end
	end

	always @(posedge clk) begin : monitor
		console_report_t want;
		console_report_t rep;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_reports.size() == 0) begin
					fail_count++;
					$display("%0t: result expected none, got col %0d row %0d cell %0h",
						$time, cursor_col_out, cursor_row_out, cell_value);
				end else begin
					want = predicted_reports.pop_front();
					check_field("cursor_col_out", 32'(want.col), 32'(cursor_col_out));
					check_field("cursor_row_out", 32'(want.row), 32'(cursor_row_out));
					check_field("cell_value", 32'(want.cell_val), 32'(cell_value));
					check_field("scrolled", 32'(want.scrolled), 32'(scrolled));
				end
			end
			if (in_valid && in_ready) begin
				apply_console_cmd('{command, char_code, read_row, read_col}, rep);
				predicted_reports.push_back(rep);
			end
			in_taken <= in_valid && in_ready;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [ATTR_W-1:0] next_attr;
		blank_screen();
		model_cursor = '0;
		model_attr = ATTR_RESET;
		plan_cursor = '0;
		scrolls_left = SCROLL_QUOTA;

		// directed: reset contents, byte extremes, tab, newline, odd reads
		queue_cmd(CMD_READ, 8'h00, 5'd0, 7'd0);
		queue_cmd(CMD_PUT, 8'h00, 5'd31, 7'd127);
		queue_cmd(CMD_PUT, 8'hFF, 5'd0, 7'd0);
		queue_cmd(CMD_PUT, 8'h80, 5'd0, 7'd0);
		queue_cmd(CMD_PUT, 8'h01, 5'd0, 7'd0);
		queue_cmd(CMD_PUT, CHAR_TAB, 5'd0, 7'd0);
		queue_cmd(CMD_PUT, 8'hFE, 5'd0, 7'd0);
		queue_cmd(CMD_READ, 8'hFF, 5'd0, 7'd1);
		queue_cmd(CMD_READ, 8'h00, 5'd0, 7'd8);
		queue_cmd(CMD_READ, 8'h00, 5'd0, 7'd5);
		queue_cmd(CMD_PUT, CHAR_NEWLINE, 5'd0, 7'd0);
		queue_cmd(CMD_UNUSED, 8'hFF, 5'd31, 7'd127);
		queue_cmd(CMD_READ, 8'h00, 5'd31, 7'd0);
		queue_cmd(CMD_READ, 8'h00, 5'd0, 7'd127);
		queue_cmd(CMD_READ, 8'h00, 5'd24, 7'd79);
		queue_cmd(CMD_READ, 8'h00, 5'd25, 7'd80);
		queue_cmd(CMD_READ, 8'h00, 5'd0, 7'd80);
		queue_cmd(CMD_PUT, 8'h41, 5'd0, 7'd0);
		queue_cmd(CMD_READ, 8'h00, 5'd1, 7'd0);
		queue_cmd(CMD_CLEAR, 8'hFF, 5'd31, 7'd127);
		queue_cmd(CMD_READ, 8'h00, 5'd0, 7'd1);
		queue_cmd(CMD_READ, 8'h00, 5'd1, 7'd0);
		queue_random_phase(300);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int p = 1; p < PHASES; p++) begin
			wait_until_drained();
			case (p)
				1: next_attr = 8'h00;
				2: next_attr = 8'hFF;
				4: next_attr = 8'h80;
				default: next_attr = ATTR_W'($urandom_range(255));
			endcase
			wr_en <= 1'b1;
			wr_data <= next_attr;
			@(negedge clk);
			wr_en <= 1'b0;
			model_attr = next_attr;
			@(posedge clk);
			// one phase with both sides always ready
			idle_on = (p != 3);
			queue_random_phase(340);
		end

		wait_until_drained();
		repeat (12) @(negedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
